>>> rtl/core/prfr_pkg.sv
// ----------------------------------------------------------------------------
// Resampler package
// Shared item types, command and sequencer codes of the polyphase resampler.
// ----------------------------------------------------------------------------
package prfr_pkg;

  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // One sample never produces more than this many outputs.
  localparam int unsigned MAX_RESULTS = 4;

  typedef struct packed {
    logic               op;
    logic [7:0]         coef_index;
    logic signed [15:0] coef_value;
    logic signed [15:0] sample;
    logic [22:0]        time_step;
  } in_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               last;
  } out_t;

  typedef enum logic [1:0] {
    CMD_COEF,
    CMD_SAMPLE,
    CMD_SKIP
  } cmd_e;

  typedef struct packed {
    cmd_e               kind;
    logic [7:0]         coef_index;
    logic signed [15:0] coef_value;
    logic signed [15:0] sample;
    logic [22:0]        time_step;
  } cmd_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_CALC,
    ENG_MUL,
    ENG_SUM,
    ENG_EMIT
  } eng_e;

endpackage

>>> rtl/core/prfr_fifo.sv
// ----------------------------------------------------------------------------
// Resampler queue
// Small first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module prfr_fifo #(
  parameter type item_t = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  input  item_t wr_data_i,
  output logic  full_o,
  input  logic  rd_ready_i,
  output item_t rd_data_o,
  output logic  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t          mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  count_q;
  logic           do_wr, do_rd;

  assign full_o    = (count_q == CW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_valid_i && !full_o;
  assign do_rd     = rd_ready_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> rtl/core/prfr_front.sv
// ----------------------------------------------------------------------------
// Resampler front end
// Accepts items, sorts them into commands and queues them for the engine.
// ----------------------------------------------------------------------------
module prfr_front
  import prfr_pkg::*;
#(
  parameter int unsigned PHASES = 16,
  parameter int unsigned TAPS   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  in_t  in_data_i,
  output logic full_o,
  input  logic cmd_pop_i,
  output cmd_t cmd_o,
  output logic cmd_empty_o
);

  localparam int unsigned NCOEF    = PHASES * TAPS;
  localparam logic [22:0] MIN_STEP = 23'(PHASES * 16384);

  cmd_t cmd;

  // Steps below a quarter sample are raised so that one sample gives at most
  // four outputs; coefficient writes past the table are dropped.
  always_comb begin
    cmd.coef_index = in_data_i.coef_index;
    cmd.coef_value = in_data_i.coef_value;
    cmd.sample     = in_data_i.sample;
    cmd.time_step  = (in_data_i.time_step < MIN_STEP) ? MIN_STEP : in_data_i.time_step;
    if (in_data_i.op == OP_SAMPLE) begin
      cmd.kind = CMD_SAMPLE;
    end else if (32'(in_data_i.coef_index) < NCOEF) begin
      cmd.kind = CMD_COEF;
    end else begin
      cmd.kind = CMD_SKIP;
    end
  end

  prfr_fifo #(
    .item_t(cmd_t),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(push_i),
    .wr_data_i (cmd),
    .full_o    (full_o),
    .rd_ready_i(cmd_pop_i),
    .rd_data_o (cmd_o),
    .empty_o   (cmd_empty_o)
  );

endmodule

>>> rtl/core/prfr_back.sv
// ----------------------------------------------------------------------------
// Resampler engine
// Holds coefficients, history and output time; runs the serial MAC per output.
// ----------------------------------------------------------------------------
module prfr_back
  import prfr_pkg::*;
#(
  parameter int unsigned PHASES = 16,
  parameter int unsigned TAPS   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_empty_i,
  output logic cmd_pop_o,
  output out_t res_o,
  output logic res_push_o,
  input  logic res_full_i
);

  localparam int unsigned NCOEF  = PHASES * TAPS;
  localparam int unsigned CA_W   = $clog2(NCOEF);
  localparam int unsigned PH_W   = $clog2(PHASES);
  localparam int unsigned TI_W   = $clog2(TAPS);
  localparam int unsigned HI_W   = $clog2(TAPS + 1);
  localparam int unsigned J_W    = $clog2(2 * TAPS + 2);
  localparam int unsigned CNT_W  = $clog2(MAX_RESULTS);
  localparam int unsigned ACC_W  = 33 + $clog2(TAPS);
  localparam int unsigned INT_W  = ACC_W + 18;
  localparam int unsigned SUM_W  = ACC_W + 19;
  localparam int unsigned Q_W    = SUM_W - 31;
  localparam logic [15:0] WIN_END  = 16'((TAPS + 1) * PHASES);
  localparam logic [15:0] WIN_BASE = 16'(TAPS * PHASES);
  localparam logic [31:0] T_RESET  = 32'(TAPS * PHASES) << 16;
  localparam logic [31:0] T_SAMPLE = 32'(PHASES) << 16;
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << 30;

  eng_e state_q, state_d;

  logic signed [15:0] coef_mem [NCOEF];
  logic signed [15:0] hist_q [TAPS + 1];
  logic [31:0]        time_q, time_next;
  logic [22:0]        step_q;
  logic [J_W-1:0]     j_q;
  logic [CNT_W-1:0]   cnt_q;

  logic signed [15:0]       coef_rd_q, hist_rd_q;
  logic                     vld_b_q, vld_c_q, tag_b_q, tag_c_q;
  logic signed [31:0]       prod_q;
  logic signed [ACC_W-1:0]  y1_q, y2_q;
  logic signed [INT_W-1:0]  interp_q;
  logic signed [15:0]       value_q;

  // Control decoded from the state.
  logic idle_take, mem_we, hist_shift, start_calc, issue, emit, last;
  logic in_window;

  logic [15:0]      k_off;
  logic [PH_W-1:0]  p1, phase_sel;
  logic             wrap, half;
  logic [J_W-1:0]   j_rel;
  logic [TI_W-1:0]  tap_i;
  logic [CA_W-1:0]  rd_addr, wr_addr;
  logic [CA_W+7:0]  wr_addr_ext;
  logic [HI_W-1:0]  hidx;

  logic signed [ACC_W:0]    diff;
  logic signed [SUM_W-1:0]  sum;
  logic signed [Q_W-1:0]    q;

  assign in_window = (time_q[31:16] < WIN_END);
  assign time_next = time_q + 32'(step_q);
  assign last      = (time_next[31:16] >= WIN_END) || (cnt_q == CNT_W'(MAX_RESULTS - 1));

  // The output time always sits in the last sample period, so the first
  // phase is the offset into it and the second one may wrap to the next.
  assign k_off     = time_q[31:16] - WIN_BASE;
  assign p1        = k_off[PH_W-1:0];
  assign wrap      = (p1 == PH_W'(PHASES - 1));
  assign half      = (j_q >= J_W'(TAPS));
  assign j_rel     = half ? j_q - J_W'(TAPS) : j_q;
  assign tap_i     = j_rel[TI_W-1:0];
  assign phase_sel = !half ? p1 : (wrap ? '0 : p1 + 1'b1);
  assign rd_addr   = CA_W'(phase_sel) * CA_W'(TAPS) + CA_W'(tap_i);
  assign hidx      = ((half && wrap) ? HI_W'(TAPS) : HI_W'(TAPS - 1)) - HI_W'(tap_i);

  assign wr_addr_ext = {{CA_W{1'b0}}, cmd_i.coef_index};
  assign wr_addr     = wr_addr_ext[CA_W-1:0];

  assign diff = (ACC_W + 1)'(y2_q) - (ACC_W + 1)'(y1_q);
  assign sum  = (SUM_W'(y1_q) <<< 16) + SUM_W'(interp_q) + RND_HALF;
  assign q    = Q_W'(sum >>> 31);

  assign res_o.value = value_q;
  assign res_o.last  = last;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ENG_IDLE: begin
        if (!cmd_empty_i && cmd_i.kind == CMD_SAMPLE && in_window) begin
          state_d = ENG_CALC;
        end
      end
      ENG_CALC: begin
        if (j_q == J_W'(2 * TAPS + 1)) begin
          state_d = ENG_MUL;
        end
      end
      ENG_MUL:  state_d = ENG_SUM;
      ENG_SUM:  state_d = ENG_EMIT;
      ENG_EMIT: begin
        if (!res_full_i) begin
          state_d = last ? ENG_IDLE : ENG_CALC;
        end
      end
      default:  state_d = ENG_IDLE;
    endcase
  end

  always_comb begin
    idle_take  = (state_q == ENG_IDLE) && !cmd_empty_i;
    cmd_pop_o  = idle_take;
    mem_we     = idle_take && (cmd_i.kind == CMD_COEF);
    hist_shift = idle_take && (cmd_i.kind == CMD_SAMPLE);
    issue      = (state_q == ENG_CALC) && (j_q < J_W'(2 * TAPS));
    emit       = (state_q == ENG_EMIT) && !res_full_i;
    res_push_o = emit;
    start_calc = (hist_shift && in_window) || (emit && !last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ENG_IDLE;
      time_q  <= T_RESET;
      j_q     <= '0;
      cnt_q   <= '0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      for (int h = 0; h <= TAPS; h++) begin
        hist_q[h] <= '0;
      end
    end else begin
      state_q <= state_d;
      vld_b_q <= issue;
      vld_c_q <= vld_b_q;
      if (hist_shift) begin
        for (int h = 0; h < TAPS; h++) begin
          hist_q[h] <= hist_q[h + 1];
        end
        hist_q[TAPS] <= cmd_i.sample;
        cnt_q        <= '0;
        if (!in_window) begin
          time_q <= time_q - T_SAMPLE;
        end
      end
      if (start_calc) begin
        j_q <= '0;
      end else if (state_q == ENG_CALC) begin
        j_q <= j_q + 1'b1;
      end
      if (emit) begin
        cnt_q  <= cnt_q + 1'b1;
        time_q <= last ? time_next - T_SAMPLE : time_next;
      end
    end
  end

  // Coefficient memory and the read pipeline of the MAC.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      coef_mem[wr_addr] <= cmd_i.coef_value;
    end
    coef_rd_q <= coef_mem[rd_addr];
    hist_rd_q <= hist_q[hidx];
    tag_b_q   <= half;
    tag_c_q   <= tag_b_q;
    prod_q    <= coef_rd_q * hist_rd_q;
    if (hist_shift) begin
      step_q <= cmd_i.time_step;
    end
    if (start_calc) begin
      y1_q <= '0;
      y2_q <= '0;
    end else if (vld_c_q) begin
      if (tag_c_q) begin
        y2_q <= y2_q + ACC_W'(prod_q);
      end else begin
        y1_q <= y1_q + ACC_W'(prod_q);
      end
    end
    if (state_q == ENG_MUL) begin
      interp_q <= INT_W'(diff) * INT_W'($signed({1'b0, time_q[15:0]}));
    end
    if (state_q == ENG_SUM) begin
      if (q > Q_W'(32767)) begin
        value_q <= 16'sh7fff;
      end else if (q < -Q_W'(32768)) begin
        value_q <= -16'sh8000;
      end else begin
        value_q <= q[15:0];
      end
    end
  end

endmodule

>>> rtl/core/polyphase_fractional_resampler_core.sv
// A coefficient item is written into the table when the engine takes it. A
// sample item gives its outputs one after another, each through the CALC,
// MUL, SUM and EMIT states of the single MAC. Throughput: one item per cycle
// while the engine is idle and the item gives no output; a sample with outputs
// holds it until its last output is pushed; both queues hold two entries.
// Reset clears history to zero and the output time to TAPS*PHASES phases.
// ----------------------------------------------------------------------------
// Polyphase fractional resampler
// Arbitrary-ratio polyphase FIR resampler with linear phase interpolation.
// ----------------------------------------------------------------------------
module polyphase_fractional_resampler_core
  import prfr_pkg::*;
#(
  parameter int unsigned PHASES = 16,
  parameter int unsigned TAPS   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  input  in_t  in_data_i,
  output logic full,
  input  logic pop,
  output out_t out_data_o,
  output logic empty
);

  cmd_t cmd;
  logic cmd_empty, cmd_pop;
  out_t res;
  logic res_push, res_full;

  prfr_front #(
    .PHASES(PHASES),
    .TAPS  (TAPS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .full_o     (full),
    .cmd_pop_i  (cmd_pop),
    .cmd_o      (cmd),
    .cmd_empty_o(cmd_empty)
  );

  prfr_back #(
    .PHASES(PHASES),
    .TAPS  (TAPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_o      (res),
    .res_push_o (res_push),
    .res_full_i (res_full)
  );

  prfr_fifo #(
    .item_t(out_t),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(res_push),
    .wr_data_i (res),
    .full_o    (res_full),
    .rd_ready_i(pop),
    .rd_data_o (out_data_o),
    .empty_o   (empty)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Resampler core testbench
// Loads the polyphase table, streams samples with random steps and idles on
// both sides, and compares every output against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb;
  import prfr_pkg::*;

  localparam int unsigned PH = 16;
  localparam int unsigned TP = 16;
  localparam int unsigned NCOEF = PH * TP;
  localparam logic [31:0] WIN_END = 32'((TP + 1) * PH);
  localparam logic [22:0] MIN_STEP = 23'(PH * 16384);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  in_t  in_data_i = '0;
  logic full;
  logic pop = 1'b0;
  out_t out_data_o;
  logic empty;

  polyphase_fractional_resampler_core #(.PHASES(PH), .TAPS(TP)) dut (.*);

  always #4 clk_i = ~clk_i;

  // Predictor state.
  logic signed [15:0] taps_q[NCOEF];
  logic signed [15:0] hist_q[TP + 1];
  logic [31:0]        out_time;
  out_t               expected_outputs[$];
  in_t                pending_items[$];
  int                 errors = 0;
  int                 n_outputs = 0;
  int                 n_samples = 0;
  bit                 hold_sender = 1'b0;

  function automatic longint phase_sum(int unsigned phase, int unsigned pos);
    longint acc;
    int     idx;
    acc = 0;
    for (int i = 0; i < TP; i++) begin
      idx = int'(pos) - 1 - i;
      if (idx >= 0 && idx <= TP) acc += longint'(taps_q[phase * TP + i]) * hist_q[idx];
    end
    return acc;
  endfunction

  task automatic predict_item(in_t it);
    logic [22:0] stp;
    int unsigned k, n;
    longint y1, y2, acc, q;
    out_t o;
    if (it.op == OP_COEF) begin
      if (it.coef_index < NCOEF) taps_q[it.coef_index] = it.coef_value;
      return;
    end
    n_samples++;
    for (int i = 0; i < TP; i++) hist_q[i] = hist_q[i + 1];
    hist_q[TP] = it.sample;
    stp = (it.time_step < MIN_STEP) ? MIN_STEP : it.time_step;
    n = 0;
    while ((out_time >> 16) < WIN_END && n < MAX_RESULTS) begin
      k = out_time >> 16;
      y1 = phase_sum(k % PH, k / PH);
      y2 = phase_sum((k + 1) % PH, (k + 1) / PH);
      acc = y1 * 65536 + (y2 - y1) * longint'(out_time[15:0]);
      q = (acc + (longint'(1) << 30)) >>> 31;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      o.value = q[15:0];
      o.last = 1'b0;
      expected_outputs.push_back(o);
      n++;
      out_time += stp;
    end
    if (n > 0) expected_outputs[$].last = 1'b1;
    out_time -= PH << 16;
  endtask

  function automatic in_t rand_sample();
    in_t it;
    it = '0;
    it.op = OP_SAMPLE;
    it.coef_index = 8'($urandom);
    it.coef_value = 16'($urandom);
    it.sample = 16'($urandom);
    case ($urandom_range(0, 5))
      0: it.time_step = 23'($urandom);                    // may be below the floor
      1: it.time_step = 23'($urandom_range(262144, 4194304));
      default: it.time_step = 23'($urandom_range(PH * 65536 - 40000, PH * 65536 + 40000));
    endcase
    return it;
  endfunction

  function automatic in_t coef_item(int unsigned idx, logic [15:0] v);
    in_t it;
    it = in_t'({$urandom, $urandom});
    it.op = OP_COEF;
    it.coef_index = 8'(idx);
    it.coef_value = v;
    return it;
  endfunction

  // Driver.
  int gap = 0;
  always @(posedge clk_i) begin
    if (push && !full) begin
      predict_item(in_data_i);
      void'(pending_items.pop_front());
      gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 10);
    end
    if (push && !full) begin
      push <= 1'b0;
    end else if (!push && rst_ni && pending_items.size() > 0 && !hold_sender) begin
      if (gap > 0) gap <= gap - 1;
      else begin
        push <= 1'b1;
        in_data_i <= pending_items[0];
      end
    end
  end

  // Monitor.
  int stall = 0;
  always @(posedge clk_i) begin
    if (pop && !empty) begin
      n_outputs++;
      if (expected_outputs.size() == 0) begin
        $error("unexpected output value=%0d last=%0b", out_data_o.value, out_data_o.last);
        errors++;
      end else begin
        out_t e;
        e = expected_outputs.pop_front();
        if (out_data_o.value !== e.value) begin
          $error("value: expected %0d, got %0d", e.value, out_data_o.value);
          errors++;
        end
        if (out_data_o.last !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, out_data_o.last);
          errors++;
        end
      end
      stall = $urandom_range(0, 2) ? 0 : $urandom_range(0, 10);
    end
    if (stall > 0) begin
      stall--;
      pop <= 1'b0;
    end else pop <= 1'b1;
  end

  initial begin
    for (int i = 0; i <= TP; i++) hist_q[i] = '0;
    for (int i = 0; i < NCOEF; i++) taps_q[i] = '0;
    out_time = (TP * PH) << 16;
    // Directed: full table with extremes, then a write to the last table address.
    for (int i = 0; i < NCOEF; i++)
      pending_items.push_back(coef_item(i, (i % 37 == 0) ? 16'h7fff :
                                           (i % 41 == 0) ? 16'h8000 : 16'($urandom)));
    pending_items.push_back(coef_item(8'hff, 16'h8000));
    for (int i = 0; i < 20; i++) begin
      in_t it;
      it = rand_sample();
      it.sample = (i % 2) ? 16'sh7fff : 16'sh8000;
      it.coef_index = (i % 2) ? 8'hff : 8'h00;
      it.coef_value = (i % 2) ? 16'hffff : 16'h0000;
      it.time_step = (i < 6) ? 23'd0 : (i < 10) ? 23'h7fffff :
                     (i < 14) ? 23'd262144 : 23'd4194304;
      pending_items.push_back(it);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_items.size() == 0);
    // Let everything drain with the sender held.
    hold_sender = 1'b1;
    wait (expected_outputs.size() == 0);
    repeat (60) @(posedge clk_i);
    hold_sender = 1'b0;
    for (int i = 0; i < 183; i++) begin
      if ($urandom_range(0, 19) == 0) pending_items.push_back(coef_item($urandom, $urandom));
      else pending_items.push_back(rand_sample());
    end
    wait (pending_items.size() == 0 && !push);
    wait (expected_outputs.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d samples and %0d outputs, table reloads and step extremes.",
             n_samples, n_outputs);
    if (errors == 0 && expected_outputs.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
